### hdl/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [1:0]               t_req;
    typedef logic [1:0]               t_status;

    localparam t_req REQ_PUSH_FRONT = 2'd0;
    localparam t_req REQ_PUSH_REAR  = 2'd1;
    localparam t_req REQ_POP_FRONT  = 2'd2;
    localparam t_req REQ_POP_REAR   = 2'd3;

    localparam t_status ST_DONE     = 2'd0;
    localparam t_status ST_OVERFLOW = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;

    localparam t_idx IDX_LAST = IDX_W'(DEPTH - 1);

    function automatic t_idx idx_next(input t_idx i);
        return (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic t_idx idx_prev(input t_idx i);
        return (i == '0) ? IDX_LAST : i - 1'b1;
    endfunction

endpackage

### hdl/cdq_ram.sv
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/circular_deque.sv
`timescale 1ns / 1ps

// circular double-ended queue of signed 32-bit values, cdq_pkg::DEPTH entries deep. each request
// transfer pushes at the front or rear or pops from the front or rear and gives exactly one result
// transfer: pop_value (0 unless a pop succeeded) and status (done, overflow on a push to a full
// deque, empty on a pop from an empty deque). an accepted request holds off the next one until its
// result is loaded: the indices update and the entry store is written or read in the accept cycle,
// and the result register is loaded from the store's registered read port once it is free.
// the result register lets a new request be taken while a result still waits to be transferred.
// a push to an empty deque always lands in entry 0 and a pop of the last entry resets both ends.
module circular_deque (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cdq_pkg::t_req        i_req_type,
    input  cdq_pkg::t_data       i_push_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cdq_pkg::t_data       o_pop_value,
    output cdq_pkg::t_status     o_status
);

    cdq_pkg::t_idx    r_front, n_front;
    cdq_pkg::t_idx    r_rear, n_rear;
    logic             r_empty, n_empty;
    logic             r_busy, n_busy;
    logic             r_pend_pop, n_pend_pop;
    cdq_pkg::t_status r_pend_status, n_pend_status;
    logic             r_out_valid, n_out_valid;
    cdq_pkg::t_data   r_pop_value, n_pop_value;
    cdq_pkg::t_status r_status, n_status;

    logic             in_xfer;
    logic             out_load;
    logic             is_push;
    logic             is_full;
    logic             wr_en;
    cdq_pkg::t_idx    wr_addr;
    cdq_pkg::t_idx    rd_addr;
    cdq_pkg::t_data   rd_data;

    assign in_xfer  = i_in_valid && !r_busy;
    assign out_load = r_busy && (!r_out_valid || !i_out_stall);
    assign is_push  = (i_req_type == cdq_pkg::REQ_PUSH_FRONT)
                   || (i_req_type == cdq_pkg::REQ_PUSH_REAR);
    assign is_full  = !r_empty && (cdq_pkg::idx_next(r_rear) == r_front);
    assign rd_addr  = (i_req_type == cdq_pkg::REQ_POP_FRONT) ? r_front : r_rear;

    always_comb begin
        n_front       = r_front;
        n_rear        = r_rear;
        n_empty       = r_empty;
        n_busy        = r_busy;
        n_pend_pop    = r_pend_pop;
        n_pend_status = r_pend_status;
        wr_en         = 1'b0;
        wr_addr       = '0;

        if (out_load) begin
            n_busy = 1'b0;
        end

        if (in_xfer) begin
            n_busy        = 1'b1;
            n_pend_pop    = 1'b0;
            n_pend_status = cdq_pkg::ST_DONE;
            case (i_req_type)
                cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_REAR: begin
                    if (r_empty) begin
                        n_empty = 1'b0;
                        n_front = '0;
                        n_rear  = '0;
                        wr_en   = 1'b1;
                        wr_addr = '0;
                    end else if (is_full) begin
                        n_pend_status = cdq_pkg::ST_OVERFLOW;
                    end else if (i_req_type == cdq_pkg::REQ_PUSH_FRONT) begin
                        n_front = cdq_pkg::idx_prev(r_front);
                        wr_en   = 1'b1;
                        wr_addr = cdq_pkg::idx_prev(r_front);
                    end else begin
                        n_rear  = cdq_pkg::idx_next(r_rear);
                        wr_en   = 1'b1;
                        wr_addr = cdq_pkg::idx_next(r_rear);
                    end
                end
                cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_REAR: begin
                    if (r_empty) begin
                        n_pend_status = cdq_pkg::ST_EMPTY;
                    end else begin
                        n_pend_pop = 1'b1;
                        if (r_front == r_rear) begin
                            n_empty = 1'b1;
                            n_front = '0;
                            n_rear  = '0;
                        end else if (i_req_type == cdq_pkg::REQ_POP_FRONT) begin
                            n_front = cdq_pkg::idx_next(r_front);
                        end else begin
                            n_rear = cdq_pkg::idx_prev(r_rear);
                        end
                    end
                end
                default: begin
                    n_pend_status = cdq_pkg::ST_DONE;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_pop_value = r_pop_value;
        n_status    = r_status;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
            n_pop_value = r_pend_pop ? rd_data : '0;
            n_status    = r_pend_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_rear      <= '0;
            r_empty     <= 1'b1;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_empty     <= n_empty;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_pop    <= n_pend_pop;
        r_pend_status <= n_pend_status;
        r_pop_value   <= n_pop_value;
        r_status      <= n_status;
    end

    cdq_ram #(
        .DEPTH (cdq_pkg::DEPTH),
        .WIDTH (cdq_pkg::DATA_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_push_value),
        .i_rd_en   (in_xfer && !is_push),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;

    // an empty deque keeps both ends at entry 0
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_front == '0) && (r_rear == '0))
        else $error("empty deque with ends away from entry 0");

    // a failed request never carries data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != cdq_pkg::ST_DONE) |-> (o_pop_value == '0))
        else $error("failed request carries data");

    // every result comes from a request held in the busy cycle
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_busy))
        else $error("result without a pending request");

    // a full deque refuses a push without moving either end
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && is_push && is_full |=> $stable(r_front) && $stable(r_rear)
            && (r_pend_status == cdq_pkg::ST_OVERFLOW))
        else $error("push to full deque changed state");

endmodule

### bench/circular_deque_checker.sv
`timescale 1ns / 1ps

module circular_deque_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  cdq_pkg::t_req        i_req_type,
    input  cdq_pkg::t_data       i_push_value,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  cdq_pkg::t_data       i_pop_value,
    input  cdq_pkg::t_status     i_status,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        cdq_pkg::t_data   pop_value;
        cdq_pkg::t_status status;
    } t_deque_result;

    cdq_pkg::t_data slots [cdq_pkg::DEPTH];
    int             head_pos;
    int             tail_pos;
    logic           deque_empty;
    t_deque_result  expected_results [$];

    function automatic t_deque_result deque_step(input cdq_pkg::t_req req,
                                                 input cdq_pkg::t_data value);
        t_deque_result res;
        res.pop_value = '0;
        res.status    = cdq_pkg::ST_DONE;
        if (req == cdq_pkg::REQ_PUSH_FRONT || req == cdq_pkg::REQ_PUSH_REAR) begin
            if (deque_empty) begin
                deque_empty = 1'b0;
                head_pos    = 0;
                tail_pos    = 0;
                slots[0]    = value;
            end else if ((tail_pos + 1) % cdq_pkg::DEPTH == head_pos) begin
                res.status = cdq_pkg::ST_OVERFLOW;
            end else if (req == cdq_pkg::REQ_PUSH_FRONT) begin
                head_pos        = (head_pos + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
                slots[head_pos] = value;
            end else begin
                tail_pos        = (tail_pos + 1) % cdq_pkg::DEPTH;
                slots[tail_pos] = value;
            end
        end else begin
            if (deque_empty) begin
                res.status = cdq_pkg::ST_EMPTY;
            end else begin
                res.pop_value = (req == cdq_pkg::REQ_POP_FRONT) ? slots[head_pos]
                                                                 : slots[tail_pos];
                if (head_pos == tail_pos) begin
                    deque_empty = 1'b1;
                    head_pos    = 0;
                    tail_pos    = 0;
                end else if (req == cdq_pkg::REQ_POP_FRONT) begin
                    head_pos = (head_pos + 1) % cdq_pkg::DEPTH;
                end else begin
                    tail_pos = (tail_pos + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_deque_result want;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            head_pos    = 0;
            tail_pos    = 0;
            deque_empty = 1'b1;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            // result side first: a request accepted at this edge cannot have its result yet
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result transfer: pop_value %0d status %0d",
                             $time, i_pop_value, i_status);
                    errs++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_pop_value !== want.pop_value) begin
                        $display("%0t pop_value mismatch: expected %0d actual %0d",
                                 $time, want.pop_value, i_pop_value);
                        errs++;
                    end
                    if (i_status !== want.status) begin
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, i_status);
                        errs++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(deque_step(i_req_type, i_push_value));
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= expected_results.size();
        end
    end

endmodule

### bench/circular_deque_tb.sv
`timescale 1ns / 1ps

module circular_deque_tb;

    localparam int RANDOM_ITEMS = 1625;
    localparam int HOLD_CYCLES  = 80;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 10;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             in_valid     = 1'b0;
    cdq_pkg::t_req    req_type     = cdq_pkg::REQ_PUSH_FRONT;
    cdq_pkg::t_data   push_value   = '0;
    logic             out_stall    = 1'b0;
    logic             in_stall;
    logic             out_valid;
    cdq_pkg::t_data   pop_value;
    cdq_pkg::t_status status;
    int               fail_count;
    int               pending;
    int               cycle_count  = 0;
    logic             steady       = 1'b0;
    logic             hold_request = 1'b0;
    logic             hold_done    = 1'b0;

    circular_deque dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_req_type   (req_type),
        .i_push_value (push_value),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_pop_value  (pop_value),
        .o_status     (status)
    );

    circular_deque_checker u_deque_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_req_type   (req_type),
        .i_push_value (push_value),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_pop_value  (pop_value),
        .i_status     (status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("circular_deque verification failed");
            $finish;
        end
    end

    // result side: random stall, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                out_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_done = 1'b1;
                out_stall <= 1'b0;
            end else begin
                out_stall <= !steady && ($urandom_range(99) < 10);
            end
        end
    end

    task automatic send_request(input cdq_pkg::t_req req, input cdq_pkg::t_data value);
        in_valid   <= 1'b1;
        req_type   <= req;
        push_value <= value;
        do @(posedge i_clk); while (in_stall);
        if (!steady && (!hold_request || hold_done) && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    initial begin
        int             n;
        int             push_pct;
        cdq_pkg::t_req  req;
        cdq_pkg::t_data value;

        push_pct = 50;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pops, fill to full with extremes, overflow, mixed pops, drain past empty
        send_request(cdq_pkg::REQ_POP_FRONT, 32'h1234_5678);
        send_request(cdq_pkg::REQ_POP_REAR, 32'hFFFF_FFFF);
        send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
        send_request(cdq_pkg::REQ_PUSH_REAR, 32'h7FFF_FFFF);
        send_request(cdq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(cdq_pkg::REQ_PUSH_REAR, 32'h0000_0000);
        send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h5555_5555);
        send_request(cdq_pkg::REQ_PUSH_REAR, 32'hAAAA_AAAA);
        send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h0000_0001);
        send_request(cdq_pkg::REQ_PUSH_REAR, cdq_pkg::t_data'($urandom));
        send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h0F0F_0F0F);
        send_request(cdq_pkg::REQ_PUSH_REAR, 32'hF0F0_F0F0);
        send_request(cdq_pkg::REQ_POP_FRONT, 32'h0);
        send_request(cdq_pkg::REQ_POP_REAR, 32'h0);
        send_request(cdq_pkg::REQ_PUSH_REAR, 32'h8000_0001);
        send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFE);
        for (n = 0; n < 4; n++)
            send_request(cdq_pkg::REQ_POP_REAR, cdq_pkg::t_data'($urandom));
        for (n = 0; n < 4; n++)
            send_request(cdq_pkg::REQ_POP_FRONT, cdq_pkg::t_data'($urandom));
        send_request(cdq_pkg::REQ_POP_FRONT, 32'h0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            if (n == 400) hold_request = 1'b1;
            steady = (n >= 800 && n < 1100);
            if (n == 1200) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if ($urandom_range(99) < push_pct)
                req = $urandom_range(1) ? cdq_pkg::REQ_PUSH_REAR : cdq_pkg::REQ_PUSH_FRONT;
            else
                req = $urandom_range(1) ? cdq_pkg::REQ_POP_REAR : cdq_pkg::REQ_POP_FRONT;
            case ($urandom_range(9))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7FFF_FFFF;
                2:       value = 32'h0000_0000;
                3:       value = 32'hFFFF_FFFF;
                default: value = cdq_pkg::t_data'($urandom);
            endcase
            send_request(req, value);
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("circular_deque verification clean");
        else
            $display("circular_deque verification failed");
        $finish;
    end

endmodule

### files.f
hdl/cdq_pkg.sv
hdl/cdq_ram.sv
hdl/circular_deque.sv
bench/circular_deque_checker.sv
bench/circular_deque_tb.sv
